[rtl/core/rpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_pkg: shared types and constants for the RC throttle cruise block
// Mode codes, configuration register indexes and fixed scaling constants.
// ----------------------------------------------------------------------------
package rpt_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENGAGE_RAMP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CANCEL_RAMP = 3'd6;

    localparam logic [1:0] REQ_EDGE   = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;

    localparam logic signed [15:0] CENTER_US   = 16'sd1500;
    localparam logic signed [15:0] FULL_CENTI  = 16'sd10000;
    localparam logic signed [15:0] TOL_CENTI   = 16'sd500;
    localparam logic signed [15:0] RETREAT_CENTI = 16'sd1000;

    typedef enum logic [2:0] {
        M_IDLE      = 3'd0,
        M_SETTLING  = 3'd1,
        M_LATCHED   = 3'd2,
        M_RAMP_UP   = 3'd3,
        M_ACTIVE    = 3'd4,
        M_RAMP_DOWN = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MSCALE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_FINISH,
        S_OUT
    } seq_t;

    // ms -> us: x*1000 = (x<<10) - (x<<4) - (x<<3)
    function automatic logic [25:0] ms_to_us(input logic [15:0] ms);
        logic [25:0] x;
        x = {10'd0, ms};
        return (x << 10) - (x << 4) - (x << 3);
    endfunction

endpackage
`default_nettype wire

[rtl/core/rpt_muldiv.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_muldiv: bit-serial unsigned multiply then divide
// Computes (a * b) / d one bit per cycle; shift-add then restoring division.
// ----------------------------------------------------------------------------
module rpt_muldiv
    import rpt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [15:0]          a,
    input  wire logic [TIME_BITS-1:0] b,
    input  wire logic [25:0]          d,
    output logic                      done,
    output logic [15:0]               q
);
    localparam int PW = TIME_BITS + 16;
    localparam int CW = $clog2(PW + 1);

    logic          busy_reg, busy_next;
    logic          phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [15:0]   mcand_reg, mcand_next;
    logic [TIME_BITS-1:0] mplr_reg, mplr_next;
    logic [26:0]   rem_reg, rem_next;
    logic [26:0]   trial;
    logic          done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        cnt_reg   <= cnt_next;
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
        rem_reg   <= rem_next;
    end

    assign trial = {rem_reg[25:0], prod_reg[PW-1]} - {1'b0, d};

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        rem_next   = rem_reg;
        done_next  = 1'b0;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = CW'(TIME_BITS);
            prod_next  = '0;
            mcand_next = a;
            mplr_next  = b;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                // multiplier consumed MSB first
                prod_next = (prod_reg << 1)
                          + (mplr_reg[TIME_BITS-1] ? PW'(mcand_reg) : PW'(0));
                mplr_next = mplr_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    phase_next = 1'b1;
                    cnt_next   = CW'(PW);
                end
            end
            else
            begin
                if (!trial[26])
                begin
                    rem_next  = trial;
                    prod_next = {prod_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = {rem_reg[25:0], prod_reg[PW-1]};
                    prod_next = {prod_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = prod_reg[15:0];

    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg)
        else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg && phase_reg |=> phase_reg || !busy_reg)
        else $error("divider phase went back");

endmodule
`default_nettype wire

[rtl/core/rc_pwm_throttle_cruise.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc_pwm_throttle_cruise: RC pulse throttle decoder with cruise gesture
// Measures RC pulse widths, maps to centi-percent and runs cruise control.
// ----------------------------------------------------------------------------
// Sequence per request: S_MSCALE, S_CHECK, S_FINISH, S_OUT; a ramp adds S_MUL
// and S_DIV, where the bit-serial multiply then divide in rpt_muldiv runs.
// Throughput: one request at a time; the next is taken the cycle after the
// result is moved into the output register, which waits while out_stall holds it.
// Reset: asynchronous, active low; config to defaults, cruise idle, no pulse.
module rc_pwm_throttle_cruise
    import rpt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            req_type,
    input  wire logic [TIME_BITS-1:0]  time_us,
    input  wire logic                  pin_level,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [14:0]         throttle_centi,
    output logic                       signal_valid,
    output logic                       cruising,
    output logic [11:0]                pulse_width_us,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int TW = TIME_BITS;

    // configuration
    logic [11:0] pmin_reg, pmax_reg;
    logic [8:0]  db_reg;
    logic [15:0] tmo_reg, settle_reg, eramp_reg, cramp_reg;

    // state
    seq_t        seq_reg, seq_next;
    mode_t       mode_reg, mode_next;
    logic signed [14:0] cl_reg, cl_next, sl_reg, sl_next, ef_reg, ef_next;
    logic signed [14:0] rf_reg, rf_next;
    logic [TW-1:0] sb_reg, sb_next, eb_reg, eb_next, rb_reg, rb_next;
    logic [TW-1:0] rise_reg, rise_next, gt_reg, gt_next;
    logic        cr_reg, cr_next, rs_reg, rs_next, eg_reg, eg_next;
    logic [11:0] gw_reg, gw_next;

    // request latch and work registers
    logic [1:0]    req_reg, req_next;
    logic [TW-1:0] now_reg, now_next;
    logic          pin_reg, pin_next;
    logic [25:0]   tmo_us_reg, set_us_reg, er_us_reg, cr_us_reg;
    logic [TW-1:0] el_reg, el_next;
    logic signed [14:0] thr_reg, thr_next;
    logic          ov_reg, ov_next;
    logic signed [14:0] othr_reg, othr_next;
    logic          osv_reg, osv_next, ocr_reg, ocr_next;
    logic [11:0]   opw_reg, opw_next;

    // ramp unit
    logic          md_start;
    logic [15:0]   md_a;
    logic [TW-1:0] md_b;
    logic [25:0]   md_d;
    logic          md_done;
    logic [15:0]   md_q;
    logic          md_neg_reg, md_neg_next;

    rpt_muldiv #(.TIME_BITS(TIME_BITS)) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (md_a),
        .b     (md_b),
        .d     (md_d),
        .done  (md_done),
        .q     (md_q)
    );

    // register writes wait while a request is offered, so they never
    // coincide with an accepted request
    assign cfg_ready = (seq_reg == S_IDLE) && !in_valid;
    assign in_stall  = (seq_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmin_reg   <= 12'd800;
            pmax_reg   <= 12'd2200;
            db_reg     <= 9'd30;
            tmo_reg    <= 16'd200;
            settle_reg <= 16'd2000;
            eramp_reg  <= 16'd500;
            cramp_reg  <= 16'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PULSE_MIN:   pmin_reg   <= cfg_data[11:0];
                CFG_PULSE_MAX:   pmax_reg   <= cfg_data[11:0];
                CFG_DEADBAND:    db_reg     <= cfg_data[8:0];
                CFG_TIMEOUT:     tmo_reg    <= cfg_data;
                CFG_SETTLE:      settle_reg <= cfg_data;
                CFG_ENGAGE_RAMP: eramp_reg  <= cfg_data;
                CFG_CANCEL_RAMP: cramp_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= S_IDLE;
            mode_reg <= M_IDLE;
            cl_reg <= '0; sl_reg <= '0; ef_reg <= '0; rf_reg <= '0;
            sb_reg <= '0; eb_reg <= '0; rb_reg <= '0; rise_reg <= '0; gt_reg <= '0;
            cr_reg <= 1'b0; rs_reg <= 1'b0; eg_reg <= 1'b0;
            gw_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            seq_reg  <= seq_next;
            mode_reg <= mode_next;
            cl_reg <= cl_next; sl_reg <= sl_next; ef_reg <= ef_next; rf_reg <= rf_next;
            sb_reg <= sb_next; eb_reg <= eb_next; rb_reg <= rb_next;
            rise_reg <= rise_next; gt_reg <= gt_next;
            cr_reg <= cr_next; rs_reg <= rs_next; eg_reg <= eg_next;
            gw_reg <= gw_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        now_reg    <= now_next;
        pin_reg    <= pin_next;
        el_reg     <= el_next;
        thr_reg    <= thr_next;
        md_neg_reg <= md_neg_next;
        othr_reg   <= othr_next;
        osv_reg    <= osv_next;
        ocr_reg    <= ocr_next;
        opw_reg    <= opw_next;
        // ms-to-us scaling of the config registers, registered unconditionally
        tmo_us_reg <= ms_to_us(tmo_reg);
        set_us_reg <= ms_to_us(settle_reg);
        er_us_reg  <= ms_to_us(eramp_reg);
        cr_us_reg  <= ms_to_us(cramp_reg);
    end

    // raw throttle from latest good width
    logic signed [15:0] off, dbs;
    logic signed [19:0] rmul;
    logic signed [14:0] raw;
    always_comb
    begin
        off  = $signed({4'd0, gw_reg}) - CENTER_US;
        dbs  = $signed({7'd0, db_reg});
        rmul = 20'(off) * 20'sd20;
        if (off <= dbs && off >= -dbs)
            raw = '0;
        else if (rmul > 20'(FULL_CENTI))
            raw = 15'(FULL_CENTI);
        else if (rmul < -20'(FULL_CENTI))
            raw = -15'(FULL_CENTI);
        else
            raw = 15'(rmul);
    end

    logic [TW-1:0] el_good, el_sb, el_eb, el_rb, el_rise;
    logic          sig_ok;
    logic signed [15:0] dset;
    logic signed [15:0] diff_up;
    assign el_good = now_reg - gt_reg;
    assign el_sb   = now_reg - sb_reg;
    assign el_eb   = now_reg - eb_reg;
    assign el_rb   = now_reg - rb_reg;
    assign el_rise = now_reg - rise_reg;
    assign sig_ok  = eg_reg && (el_good < TW'(tmo_us_reg));
    assign dset    = 16'(raw) - 16'(sl_reg);
    assign diff_up = 16'(cl_reg) - 16'(ef_reg);

    always_comb
    begin
        seq_next  = seq_reg;
        mode_next = mode_reg;
        cl_next = cl_reg; sl_next = sl_reg; ef_next = ef_reg; rf_next = rf_reg;
        sb_next = sb_reg; eb_next = eb_reg; rb_next = rb_reg;
        rise_next = rise_reg; gt_next = gt_reg;
        cr_next = cr_reg; rs_next = rs_reg; eg_next = eg_reg;
        gw_next = gw_reg;
        req_next = req_reg; now_next = now_reg; pin_next = pin_reg;
        el_next = el_reg; thr_next = thr_reg; md_neg_next = md_neg_reg;
        ov_next = ov_reg;
        othr_next = othr_reg; osv_next = osv_reg; ocr_next = ocr_reg; opw_next = opw_reg;
        md_start = 1'b0;
        md_a = '0;
        md_b = el_reg;
        md_d = er_us_reg;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        unique case (seq_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    req_next = req_type;
                    now_next = time_us;
                    pin_next = pin_level;
                    thr_next = '0;
                    seq_next = S_MSCALE;
                end
            end
            S_MSCALE:
                seq_next = S_CHECK;
            S_CHECK:
            begin
                seq_next = S_FINISH;
                if (req_reg == REQ_EDGE)
                begin
                    if (pin_reg)
                    begin
                        rise_next = now_reg;
                        rs_next   = 1'b1;
                    end
                    else if (rs_reg)
                    begin
                        if (el_rise >= TW'(pmin_reg) && el_rise <= TW'(pmax_reg))
                        begin
                            gw_next = el_rise[11:0];
                            gt_next = now_reg;
                            eg_next = 1'b1;
                        end
                        rs_next = 1'b0;
                    end
                end
                else if (req_reg == REQ_CANCEL)
                begin
                    mode_next = M_IDLE; ef_next = '0; cr_next = 1'b0;
                end
                else if (req_reg == REQ_READ)
                begin
                    if (!sig_ok)
                    begin
                        mode_next = M_IDLE; ef_next = '0; cr_next = 1'b0;
                    end
                    else
                    begin
                        thr_next = raw;
                        unique case (mode_reg)
                            M_IDLE:
                            begin
                                if (raw != 0)
                                begin
                                    mode_next = M_SETTLING;
                                    sl_next = raw; sb_next = now_reg;
                                    ef_next = '0; cr_next = 1'b0;
                                end
                            end
                            M_SETTLING:
                            begin
                                if (raw == 0)
                                begin
                                    mode_next = M_IDLE; ef_next = '0; cr_next = 1'b0;
                                    thr_next = '0;
                                end
                                else
                                begin
                                    if (dset > TOL_CENTI || dset < -TOL_CENTI)
                                    begin
                                        sl_next = raw; sb_next = now_reg;
                                        if (set_us_reg == '0)
                                        begin
                                            cl_next = raw; mode_next = M_LATCHED;
                                            ef_next = '0; cr_next = 1'b0;
                                        end
                                    end
                                    else if (el_sb >= TW'(set_us_reg))
                                    begin
                                        cl_next = sl_reg; mode_next = M_LATCHED;
                                        ef_next = '0; cr_next = 1'b0;
                                    end
                                end
                            end
                            M_LATCHED:
                            begin
                                if ((cl_reg > 0 && 16'(raw) <= 16'(cl_reg) - RETREAT_CENTI) ||
                                    (cl_reg < 0 && 16'(raw) >= 16'(cl_reg) + RETREAT_CENTI))
                                begin
                                    ef_next = raw; eb_next = now_reg; cr_next = 1'b0;
                                    if (eramp_reg != '0)
                                        mode_next = M_RAMP_UP;
                                    else
                                    begin
                                        mode_next = M_ACTIVE;
                                        thr_next = cl_reg;
                                    end
                                end
                            end
                            M_RAMP_UP:
                            begin
                                if (er_us_reg == '0 || el_eb >= TW'(er_us_reg))
                                begin
                                    mode_next = M_ACTIVE;
                                    thr_next = cl_reg;
                                end
                                else
                                begin
                                    el_next = el_eb;
                                    md_neg_next = diff_up[15];
                                    seq_next = S_MUL;
                                end
                            end
                            M_ACTIVE:
                            begin
                                if (!cr_reg)
                                begin
                                    if (raw == 0)
                                        cr_next = 1'b1;
                                    thr_next = cl_reg;
                                end
                                else if (raw != 0)
                                begin
                                    mode_next = M_RAMP_DOWN;
                                    rf_next = cl_reg; rb_next = now_reg; cr_next = 1'b0;
                                    thr_next = cl_reg;
                                end
                                else if (cl_reg == 0)
                                begin
                                    mode_next = M_IDLE; ef_next = '0; cr_next = 1'b0;
                                end
                                else
                                    thr_next = cl_reg;
                            end
                            M_RAMP_DOWN:
                            begin
                                if (cr_us_reg == '0)
                                begin
                                    mode_next = M_IDLE; ef_next = '0;
                                end
                                else if (el_rb >= TW'(cr_us_reg))
                                begin
                                    mode_next = M_IDLE; ef_next = '0; rf_next = '0;
                                end
                                else
                                begin
                                    el_next = TW'(cr_us_reg) - el_rb;
                                    md_neg_next = rf_reg[14];
                                    seq_next = S_MUL;
                                end
                            end
                            default:
                            begin
                                mode_next = M_IDLE; ef_next = '0; cr_next = 1'b0;
                            end
                        endcase
                    end
                end
            end
            S_MUL:
            begin
                md_start = 1'b1;
                if (mode_reg == M_RAMP_UP)
                    md_a = md_neg_reg ? 16'(-diff_up) : 16'(diff_up);
                else
                    md_a = md_neg_reg ? 16'(-16'(rf_reg)) : 16'(rf_reg);
                seq_next = S_DIV;
            end
            S_DIV:
            begin
                md_d = (mode_reg == M_RAMP_UP) ? er_us_reg : cr_us_reg;
                if (md_done)
                begin
                    // magnitude quotient, sign applied after: truncates toward zero
                    if (mode_reg == M_RAMP_UP)
                        thr_next = 15'(16'(ef_reg) + (md_neg_reg ? -md_q : md_q));
                    else
                        thr_next = 15'(md_neg_reg ? -md_q : md_q);
                    seq_next = S_FINISH;
                end
            end
            S_FINISH:
                seq_next = S_OUT;
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next   = 1'b1;
                    othr_next = thr_reg;
                    osv_next  = sig_ok;
                    ocr_next  = (mode_reg == M_RAMP_UP) || (mode_reg == M_ACTIVE);
                    opw_next  = sig_ok ? gw_reg : '0;
                    seq_next  = S_IDLE;
                end
            end
            default:
                seq_next = S_IDLE;
        endcase
    end

    assign out_valid      = ov_reg;
    assign throttle_centi = othr_reg;
    assign signal_valid   = osv_reg;
    assign cruising       = ocr_reg;
    assign pulse_width_us = opw_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !signal_valid |-> pulse_width_us == '0)
        else $error("width shown with invalid signal");
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == S_DIV |-> mode_reg == M_RAMP_UP || mode_reg == M_RAMP_DOWN)
        else $error("ramp unit used outside a ramp");
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg != S_IDLE |-> in_stall)
        else $error("request taken while busy");

endmodule
`default_nettype wire

[tb/sv/tb_throttle_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_throttle_checker: prediction and comparison for the RC throttle block
// Watches the request, result and register channels, keeps its own copy of
// the decoder and cruise state, and compares each result with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_throttle_checker
    import rpt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [1:0]            req_type,
    input  wire logic [47:0]           time_us,
    input  wire logic                  pin_level,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic signed [14:0]    throttle_centi,
    input  wire logic                  signal_valid,
    input  wire logic                  cruising,
    input  wire logic [11:0]           pulse_width_us,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic signed [14:0] thr;
        logic               ok;
        logic               cru;
        logic [11:0]        width;
    } status_t;

    status_t status_q[$];

    logic [11:0] lim_min, lim_max, good_w;
    logic [8:0]  dead;
    logic [15:0] tmo, settle_t, eng_t, can_t;
    logic [2:0]  mode;
    int          cru_lvl, set_lvl, eng_from, rel_from;
    logic [47:0] set_t0, eng_t0, rel_t0, rise_t, good_t;
    bit          can_rdy, rise_ok, any_good;

    assign pending = status_q.size();

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic longint age(input logic [47:0] now, input logic [47:0] then);
        logic [47:0] d;
        d = now - then;
        return longint'(d);
    endfunction

    function automatic bit live(input logic [47:0] now);
        return any_good && age(now, good_t) < longint'(tmo) * 1000;
    endfunction

    function automatic void drop();
        mode = M_IDLE;
        eng_from = 0;
        can_rdy = 0;
    endfunction

    function automatic int stick_centi();
        int off, r;
        off = int'(good_w) - 1500;
        if (off <= int'(dead) && off >= -int'(dead))
            return 0;
        r = off * 20;
        if (r > 10000) r = 10000;
        if (r < -10000) r = -10000;
        return r;
    endfunction

    function automatic int cruise_step(input int raw, input logic [47:0] now);
        longint den, el;
        int d;
        case (mode)
            M_IDLE:
            begin
                if (raw != 0)
                begin
                    mode = M_SETTLING;
                    set_lvl = raw;
                    set_t0 = now;
                    eng_from = 0;
                    can_rdy = 0;
                end
                return raw;
            end
            M_SETTLING:
            begin
                if (raw == 0)
                begin
                    drop();
                    return 0;
                end
                d = raw - set_lvl;
                if (d > 500 || d < -500)
                begin
                    set_lvl = raw;
                    set_t0 = now;
                end
                if (age(now, set_t0) >= longint'(settle_t) * 1000)
                begin
                    cru_lvl = set_lvl;
                    mode = M_LATCHED;
                    eng_from = 0;
                    can_rdy = 0;
                end
                return raw;
            end
            M_LATCHED:
            begin
                if ((cru_lvl > 0 && raw <= cru_lvl - 1000) ||
                    (cru_lvl < 0 && raw >= cru_lvl + 1000))
                begin
                    eng_from = raw;
                    eng_t0 = now;
                    can_rdy = 0;
                    if (eng_t > 0)
                    begin
                        mode = M_RAMP_UP;
                        return raw;
                    end
                    mode = M_ACTIVE;
                    return cru_lvl;
                end
                return raw;
            end
            M_RAMP_UP:
            begin
                den = longint'(eng_t) * 1000;
                if (den == 0 || age(now, eng_t0) >= den)
                begin
                    mode = M_ACTIVE;
                    return cru_lvl;
                end
                el = age(now, eng_t0);
                return eng_from + int'((longint'(cru_lvl - eng_from) * el) / den);
            end
            M_ACTIVE:
            begin
                if (!can_rdy)
                begin
                    if (raw == 0)
                        can_rdy = 1;
                    return cru_lvl;
                end
                if (raw != 0)
                begin
                    mode = M_RAMP_DOWN;
                    rel_from = cru_lvl;
                    rel_t0 = now;
                    can_rdy = 0;
                    return rel_from;
                end
                if (cru_lvl == 0)
                begin
                    drop();
                    return raw;
                end
                return cru_lvl;
            end
            M_RAMP_DOWN:
            begin
                den = longint'(can_t) * 1000;
                if (den == 0)
                begin
                    mode = M_IDLE;
                    eng_from = 0;
                    return raw;
                end
                if (age(now, rel_t0) >= den)
                begin
                    mode = M_IDLE;
                    eng_from = 0;
                    rel_from = 0;
                    return raw;
                end
                el = age(now, rel_t0);
                return int'((longint'(rel_from) * (den - el)) / den);
            end
            default:
            begin
                drop();
                return raw;
            end
        endcase
    endfunction

    function automatic status_t predict(input logic [1:0] req, input logic [47:0] now,
                                        input logic lvl);
        status_t s;
        int thr;
        longint w;
        thr = 0;
        if (req == REQ_EDGE)
        begin
            if (lvl)
            begin
                rise_t = now;
                rise_ok = 1;
            end
            else if (rise_ok)
            begin
                w = age(now, rise_t);
                if (w >= lim_min && w <= lim_max)
                begin
                    good_w = w[11:0];
                    good_t = now;
                    any_good = 1;
                end
                rise_ok = 0;
            end
        end
        else if (req == REQ_READ)
        begin
            if (!live(now))
                drop();
            else
                thr = cruise_step(stick_centi(), now);
        end
        else if (req == REQ_CANCEL)
            drop();
        s.thr = thr[14:0];
        s.ok = live(now);
        s.cru = (mode == M_RAMP_UP || mode == M_ACTIVE);
        s.width = s.ok ? good_w : 12'd0;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        status_t w;
        if (!rst_n)
        begin
            lim_min = 800; lim_max = 2200; dead = 30; tmo = 200;
            settle_t = 2000; eng_t = 500; can_t = 1000;
            mode = M_IDLE;
            cru_lvl = 0; set_lvl = 0; eng_from = 0; rel_from = 0;
            set_t0 = 0; eng_t0 = 0; rel_t0 = 0; rise_t = 0; good_t = 0;
            can_rdy = 0; rise_ok = 0; any_good = 0; good_w = 0;
            fail_count = 0;
            status_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (status_q.size() == 0)
                    report("unexpected result", 0, 0);
                else
                begin
                    w = status_q.pop_front();
                    if (throttle_centi !== w.thr)
                        report("throttle_centi", throttle_centi, w.thr);
                    if (signal_valid !== w.ok)
                        report("signal_valid", signal_valid, w.ok);
                    if (cruising !== w.cru)
                        report("cruising", cruising, w.cru);
                    if (pulse_width_us !== w.width)
                        report("pulse_width_us", pulse_width_us, w.width);
                end
            end
            if (in_valid && !in_stall)
                status_q.push_back(predict(req_type, time_us, pin_level));
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_PULSE_MIN:   lim_min = cfg_data[11:0];
                    CFG_PULSE_MAX:   lim_max = cfg_data[11:0];
                    CFG_DEADBAND:    dead = cfg_data[8:0];
                    CFG_TIMEOUT:     tmo = cfg_data;
                    CFG_SETTLE:      settle_t = cfg_data;
                    CFG_ENGAGE_RAMP: eng_t = cfg_data;
                    CFG_CANCEL_RAMP: can_t = cfg_data;
                    default: ;
                endcase
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the RC throttle cruise block
// Drives directed and random edge, read and cancel requests through several
// register settings with random gaps and stalls; the checker does the rest.
// ----------------------------------------------------------------------------
module tb
    import rpt_pkg::*;
();

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0, pin_level = 0, out_stall = 0, cfg_valid = 0;
    logic [1:0] req_type = REQ_EDGE;
    logic [47:0] time_us = 0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PULSE_MIN;
    logic [CFG_DATA_W-1:0] cfg_data = 0;
    wire in_stall, out_valid, signal_valid, cruising, cfg_ready;
    wire signed [14:0] throttle_centi;
    wire [11:0] pulse_width_us;
    int fail_count, pending;
    logic [47:0] clock_us = 0;
    bit stim_done = 0;

    always #10 clk = ~clk;

    rc_pwm_throttle_cruise u_top (.*);
    tb_throttle_checker u_chk (.*);

    // valid is left high after acceptance and dropped here or by drain()
    task automatic send(input logic [1:0] req, input logic [47:0] t, input logic lvl);
        int gap;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        req_type <= req;
        time_us <= t;
        pin_level <= lvl;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // one RC pulse of given width then a read, time advancing
    task automatic pulse_and_read(input int width, input int step_us);
        send(REQ_EDGE, clock_us, 1'b1);
        clock_us += 48'(width);
        send(REQ_EDGE, clock_us, 1'b0);
        clock_us += 48'(step_us);
        send(REQ_READ, clock_us, 1'b0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic set_all(input int mn, input int mx, input int db, input int to,
                           input int st, input int er, input int cr);
        drain();
        write_reg(CFG_PULSE_MIN, 16'(mn));
        write_reg(CFG_PULSE_MAX, 16'(mx));
        write_reg(CFG_DEADBAND, 16'(db));
        write_reg(CFG_TIMEOUT, 16'(to));
        write_reg(CFG_SETTLE, 16'(st));
        write_reg(CFG_ENGAGE_RAMP, 16'(er));
        write_reg(CFG_CANCEL_RAMP, 16'(cr));
        cfg_valid <= 0;
    endtask

    // gesture: hold stick, retreat, release, push again, with noise mixed in
    task automatic random_burst(input int n);
        int w, k, hold;
        hold = $urandom_range(1000, 2400);
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 9))
                0: send(2'($urandom_range(0, 3)), 48'({$urandom, $urandom}), 1'($urandom));
                1: send(REQ_CANCEL, clock_us, 1'($urandom));
                2: send(REQ_EDGE, clock_us + $urandom_range(0, 3000), 1'($urandom));
                3: hold = $urandom_range(1000, 2400);
                4: hold = (hold > 1700) ? 1500 + $urandom_range(0, 100) : hold;
                default:
                begin
                    w = hold + $urandom_range(0, 40) - 20;
                    if ($urandom_range(0, 15) == 0) w = $urandom_range(0, 4095);
                    pulse_and_read(w, $urandom_range(0, 2) == 0 ?
                                   $urandom_range(0, 400000) : $urandom_range(0, 30000));
                    k += 2;
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // directed: extremes and the special cases
        send(REQ_EDGE, 48'd5, 1'b0);
        send(REQ_READ, 48'd10, 1'b0);
        pulse_and_read(2200, 10);
        pulse_and_read(800, 10);
        pulse_and_read(799, 10);
        pulse_and_read(2201, 10);
        pulse_and_read(1530, 10);
        pulse_and_read(2000, 10);
        send(2'd3, 48'hFFFF_FFFF_FFFF, 1'b1);
        send(REQ_EDGE, 48'hFFFF_FFFF_FFF0, 1'b1);
        send(REQ_EDGE, 48'd1200, 1'b0);
        send(REQ_READ, 48'd1300, 1'b0);
        send(REQ_CANCEL, 48'd1400, 1'b1);
        clock_us = 48'd2000;
        send(REQ_READ, clock_us + 48'd500000, 1'b0);
        set_all(0, 4095, 0, 0, 1, 0, 0);
        pulse_and_read(1501, 10);
        set_all(0, 4095, 511, 65535, 1, 0, 0);
        pulse_and_read(500, 10);
        pulse_and_read(4095, 10);
        set_all(800, 2200, 30, 200, 5, 20, 30);
        random_burst(300);
        set_all(900, 2100, 10, 100, 0, 0, 0);
        random_burst(150);
        set_all($urandom_range(0, 1000), $urandom_range(1900, 4095), $urandom_range(0, 511),
                $urandom_range(30, 600), $urandom_range(1, 40), $urandom_range(1, 60),
                $urandom_range(1, 60));
        random_burst(200);
        set_all(800, 2200, 30, 65535, 65535, 65535, 65535);
        random_burst(100);
        set_all(700, 2300, 20, 300, 2, 10, 10);
        random_burst(150);
        drain();
        stim_done = 1;
    end

    always
    begin
        int stall_len;
        stall_len = $urandom_range(0, 17);
        if (stall_len != 0)
        begin
            out_stall <= ($urandom_range(0, 3) == 0) ? 0 : ($urandom_range(0, 2) != 0);
            repeat (stall_len) @(negedge clk);
        end
        out_stall <= 0;
        @(negedge clk);
        wait (out_valid || !rst_n);
        @(negedge clk);
    end

    initial
    begin
        wait (stim_done);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb failed");
        $finish;
    end

endmodule
